/* rtl/core/shortest_queue_dispatcher_unit_assert.svh */
// assertion macros for the shortest queue dispatcher
`ifndef SHORTEST_QUEUE_DISPATCHER_UNIT_ASSERT_SVH
`define SHORTEST_QUEUE_DISPATCHER_UNIT_ASSERT_SVH

// antecedent holds, consequent holds in the same cycle
`define SQD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dispatcher check failed");

// antecedent holds, consequent holds in the next cycle
`define SQD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dispatcher sequencing check failed");

`endif

/* rtl/core/sqd_pkg.sv */
`timescale 1ns / 1ps

package sqd_pkg;

  // fixed queue count and its index width
  localparam int NUM_QUEUES = 4;
  localparam int Q_W        = 2;

  // field widths
  localparam int MODE_W  = 2;
  localparam int CNT_W   = 5;
  localparam int OUT_ID_W = 16;
  localparam int WAIT_W  = 16;
  localparam int OUT_LEN_W = 5;
  localparam int STAT_W  = 2;
  localparam int TICK_W  = 32;
  localparam int LFSR_W  = 16;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  // request modes
  localparam logic [MODE_W-1:0] MODE_ENQ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // fibonacci lfsr step, taps 16,14,13,11
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic fb;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[LFSR_W-1:1]};
  endfunction

endpackage

/* rtl/core/shortest_queue_dispatcher_unit.sv */
// sequence: an accepted request moves the sequencer to the execute state (busy
// high for one cycle), and the result strobe (done) is registered from busy
// issue: no new request is accepted while busy, since the entry memory read is
// registered; the receiver cannot stall, so results never back up
// reset: lengths, head pointers, tick counts and the id counter clear to zero,
// the tie lfsr loads 0xACE1; the entry memory is not cleared
`timescale 1ns / 1ps

module shortest_queue_dispatcher_unit
  import sqd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_WIDTH    = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [MODE_W-1:0]    mode,
  input  logic [CNT_W-1:0]     container_count,
  input  logic [Q_W-1:0]       queue_select,
  output logic                 done,
  output logic [Q_W-1:0]       queue_index,
  output logic [OUT_ID_W-1:0]  record_id,
  output logic [CNT_W-1:0]     record_containers,
  output logic [WAIT_W-1:0]    wait_ticks,
  output logic [OUT_LEN_W-1:0] queue_length,
  output logic [STAT_W-1:0]    status
);

  `include "shortest_queue_dispatcher_unit_assert.svh"

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LEN_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W   = LEN_W + 1;
  localparam int MEM_D   = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W  = $clog2(MEM_D);
  localparam int ENTRY_W = ID_WIDTH + CNT_W + TICK_W;
  localparam int EXT_W   = 32;

  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);

  // sequencer states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;

  // per-queue bookkeeping
  logic [PTR_W-1:0]    head_ptr   [NUM_QUEUES];
  logic [LEN_W-1:0]    len        [NUM_QUEUES];
  logic [TICK_W-1:0]   tick_cnt   [NUM_QUEUES];
  logic [ID_WIDTH-1:0] last_id;
  logic [LFSR_W-1:0]   tie_lfsr;

  // entry memory
  logic [ENTRY_W-1:0] entry_mem [MEM_D];
  logic [ENTRY_W-1:0] rd_data;
  logic               mem_we;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;

  // request staged across the execute cycle
  logic [Q_W-1:0]       r_q;
  logic [ID_WIDTH-1:0]  r_id;
  logic [CNT_W-1:0]     r_cnt;
  logic [TICK_W-1:0]    r_tick;
  logic [LEN_W-1:0]     r_len;
  logic [STAT_W-1:0]    r_status;
  logic                 r_pop;

  // combinational decode
  logic                accept;
  logic                all_tie;
  logic [Q_W-1:0]      min_q;
  logic [Q_W-1:0]      q_sel;
  logic [LEN_W-1:0]    q_len;
  logic [PTR_W-1:0]    q_head;
  logic [SUM_W-1:0]    tail_sum;
  logic [PTR_W-1:0]    tail_ptr;
  logic [PTR_W-1:0]    head_inc;
  logic [ID_WIDTH-1:0] id_new;
  logic                enq_ok;
  logic                deq_ok;
  logic [LEN_W-1:0]    len_after;
  logic [STAT_W-1:0]    status_now;
  logic                len_ok;

  // pop results decoded from memory
  logic [ID_WIDTH-1:0] pop_id;
  logic [CNT_W-1:0]    pop_cnt;
  logic [TICK_W-1:0]   pop_stamp;
  logic [TICK_W-1:0]   wait_diff;
  logic [WAIT_W-1:0]   wait_sat;
  logic [EXT_W-1:0]    id_ext;

  assign busy   = (state == S_EXEC);
  assign accept = start && !busy;

  // shortest queue, lowest index on ties; lfsr when all four are equal
  always_comb begin
    all_tie = (len[0] == len[1]) && (len[0] == len[2]) && (len[0] == len[3]);
    min_q   = '0;
    for (int i = 1; i < NUM_QUEUES; i++) begin
      if (len[i] < len[min_q]) begin
        min_q = Q_W'(i);
      end
    end
    if (all_tie) begin
      min_q = tie_lfsr[Q_W-1:0];
    end
  end

  // addressed queue and its pointers
  always_comb begin
    q_sel    = (mode == MODE_ENQ) ? min_q : queue_select;
    q_len    = len[q_sel];
    q_head   = head_ptr[q_sel];
    tail_sum = SUM_W'(q_head) + SUM_W'(q_len);
    if (tail_sum >= DEPTH_SUM) begin
      tail_ptr = PTR_W'(tail_sum - DEPTH_SUM);
    end else begin
      tail_ptr = PTR_W'(tail_sum);
    end
    head_inc = (q_head == LAST_PTR) ? '0 : q_head + PTR_W'(1);
    id_new   = last_id + ID_WIDTH'(1);
  end

  // operation outcome
  always_comb begin
    enq_ok     = 1'b0;
    deq_ok     = 1'b0;
    len_after  = q_len;
    status_now = ST_DONE;
    case (mode)
      MODE_ENQ: begin
        if (q_len >= DEPTH_LEN) begin
          status_now = ST_FULL;
        end else begin
          enq_ok    = 1'b1;
          len_after = q_len + LEN_W'(1);
        end
      end
      MODE_DEQ: begin
        if (q_len == '0) begin
          status_now = ST_EMPTY;
        end else begin
          deq_ok    = 1'b1;
          len_after = q_len - LEN_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // memory port request
  assign mem_we    = accept && enq_ok;
  assign mem_re    = accept && deq_ok;
  assign mem_addr  = ADDR_W'(q_sel) * ADDR_W'(QUEUE_DEPTH)
                   + ADDR_W'(enq_ok ? tail_ptr : q_head);
  assign mem_wdata = {id_new, container_count, tick_cnt[q_sel]};

  // entry memory, one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= entry_mem[mem_addr];
    end
  end

  // sequencer and per-queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      last_id  <= '0;
      tie_lfsr <= LFSR_SEED;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_ptr[i] <= '0;
        len[i]      <= '0;
        tick_cnt[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (accept) begin
        if ((mode == MODE_ENQ) && all_tie) begin
          tie_lfsr <= lfsr_step(tie_lfsr);
        end
        if (enq_ok) begin
          last_id <= id_new;
        end
        if (deq_ok) begin
          head_ptr[q_sel] <= head_inc;
        end
        if (mode == MODE_TICK) begin
          tick_cnt[q_sel] <= tick_cnt[q_sel] + TICK_W'(1);
        end
        len[q_sel] <= len_after;
      end
    end
  end

  // stage the request for the execute cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      r_q      <= q_sel;
      r_id     <= enq_ok ? id_new : '0;
      r_cnt    <= enq_ok ? container_count : '0;
      r_tick   <= tick_cnt[q_sel];
      r_len    <= len_after;
      r_status <= status_now;
      r_pop    <= deq_ok;
    end
  end

  // popped entry and saturated wait
  always_comb begin
    {pop_id, pop_cnt, pop_stamp} = rd_data;
    wait_diff = r_tick - pop_stamp;
    wait_sat  = (|wait_diff[TICK_W-1:WAIT_W]) ? '1 : wait_diff[WAIT_W-1:0];
    id_ext    = EXT_W'(r_pop ? pop_id : r_id);
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= busy;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (busy) begin
      queue_index       <= r_q;
      record_id         <= id_ext[OUT_ID_W-1:0];
      record_containers <= r_pop ? pop_cnt : r_cnt;
      wait_ticks        <= r_pop ? wait_sat : '0;
      queue_length      <= OUT_LEN_W'(r_len);
      status            <= r_status;
    end
  end

  // all lengths within the queue depth
  assign len_ok = (len[0] <= DEPTH_LEN) && (len[1] <= DEPTH_LEN)
                && (len[2] <= DEPTH_LEN) && (len[3] <= DEPTH_LEN);

  // checks
  `SQD_ASSERT_NEXT(a_accept_busy, accept, busy && !done)
  `SQD_ASSERT_NEXT(a_exec_done, busy, done && !busy)
  `SQD_ASSERT_SAME(a_len_bound, 1'b1, len_ok)

endmodule
